// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define MKD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MKD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define MKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MKD_ASSERT(label, cond, msg)
`define MKD_ASSERT_IMP(label, ante, cons, msg)
`define MKD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- design/mkd_pkg.sv -----
package mkd_pkg;

    localparam int CFG_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int KIND_W = 2;
    localparam int CODE_W = 7;

    localparam logic [CFG_W-1:0] DASH_TICKS_RESET = 16'd200;
    localparam logic [CFG_W-1:0] LETTER_TICKS_RESET = 16'd600;
    localparam logic [CFG_W-1:0] WORD_TICKS_RESET = 16'd1400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DASH_TICKS = 2'd0,
        REG_LETTER_TICKS = 2'd1,
        REG_WORD_TICKS = 2'd2
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        EV_ELEMENT = 2'd0,
        EV_LETTER = 2'd1,
        EV_ERASE = 2'd2,
        EV_WORD = 2'd3
    } event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic dash;
        logic [CODE_W-1:0] code;
    } result_t;

    typedef struct packed {
        logic [3:0] len;
        logic [7:0] bits;
        logic [CODE_W-1:0] code;
    } morse_entry_t;

    localparam logic [CODE_W-1:0] ERASE_CODE = 7'd8;
    localparam int TABLE_SIZE = 38;

    // first element is the most significant used bit, dash is 1
    localparam morse_entry_t CODE_TABLE [TABLE_SIZE] = '{
        '{4'd2, 8'd1, 7'h41}, '{4'd4, 8'd8, 7'h42}, '{4'd4, 8'd10, 7'h43},
        '{4'd3, 8'd4, 7'h44}, '{4'd1, 8'd0, 7'h45}, '{4'd4, 8'd2, 7'h46},
        '{4'd3, 8'd6, 7'h47}, '{4'd4, 8'd0, 7'h48}, '{4'd2, 8'd0, 7'h49},
        '{4'd4, 8'd7, 7'h4A}, '{4'd3, 8'd5, 7'h4B}, '{4'd4, 8'd4, 7'h4C},
        '{4'd2, 8'd3, 7'h4D}, '{4'd2, 8'd2, 7'h4E}, '{4'd3, 8'd7, 7'h4F},
        '{4'd4, 8'd6, 7'h50}, '{4'd4, 8'd13, 7'h51}, '{4'd3, 8'd2, 7'h52},
        '{4'd3, 8'd0, 7'h53}, '{4'd1, 8'd1, 7'h54}, '{4'd3, 8'd1, 7'h55},
        '{4'd4, 8'd1, 7'h56}, '{4'd3, 8'd3, 7'h57}, '{4'd4, 8'd9, 7'h58},
        '{4'd4, 8'd11, 7'h59}, '{4'd4, 8'd12, 7'h5A},
        '{4'd5, 8'd31, 7'h30}, '{4'd5, 8'd15, 7'h31}, '{4'd5, 8'd7, 7'h32},
        '{4'd5, 8'd3, 7'h33}, '{4'd5, 8'd1, 7'h34}, '{4'd5, 8'd0, 7'h35},
        '{4'd5, 8'd16, 7'h36}, '{4'd5, 8'd24, 7'h37}, '{4'd5, 8'd28, 7'h38},
        '{4'd5, 8'd30, 7'h39},
        '{4'd6, 8'd12, 7'h3F},
        '{4'd8, 8'd0, ERASE_CODE}
    };

endpackage

// ----- design/morse_key_decoder.sv -----
// Morse key decoder.
// The input channel (in_valid, in_stall, key_down) carries one sampled key
// level per word, one word per tick. The output channel (out_valid,
// out_stall, event_kind, element_dash, letter_code) carries events: an
// element (dot or dash) on each release, a letter or erase once the gap
// after the last release exceeds letter_ticks, if the symbol is in the table,
// and one word gap once it exceeds word_ticks. A tick gives at most one event.
// Each event is registered in the output word, or in the skid register.
// Throughput: one key sample per cycle while in_stall is low; the counters,
// symbol shift and code table lookup all settle before the output register.
// The write port (cfg_we, cfg_index, cfg_data) sets dash_ticks,
// letter_ticks and word_ticks; write it only while the decoder is idle.
// Reset loads the thresholds 200, 600 and 1400, clears the counters and the
// symbol, and empties the output.
// When the receiver stalls, the output word holds and one more event is
// caught in a skid register; in_stall rises only while that skid register
// is full.
`include "assert_macros.svh"

module morse_key_decoder #(
    parameter int COUNT_WIDTH = 16,
    parameter int MAX_ELEMENTS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic key_down,
    output logic out_valid,
    input  logic out_stall,
    output logic [mkd_pkg::KIND_W-1:0] event_kind,
    output logic element_dash,
    output logic [mkd_pkg::CODE_W-1:0] letter_code,
    input  logic cfg_we,
    input  logic [mkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mkd_pkg::CFG_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_ELEMENTS + 2);
    localparam int CMP_W = (COUNT_WIDTH > mkd_pkg::CFG_W) ? COUNT_WIDTH : mkd_pkg::CFG_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ELEMENTS);
    localparam logic [LEN_W-1:0] LEN_OVERFLOW = LEN_W'(MAX_ELEMENTS + 1);

    logic [mkd_pkg::CFG_W-1:0] dash_ticks_reg;
    logic [mkd_pkg::CFG_W-1:0] letter_ticks_reg;
    logic [mkd_pkg::CFG_W-1:0] word_ticks_reg;

    logic key_prev_reg, key_prev_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic [COUNT_WIDTH-1:0] gap_count_reg, gap_count_next;
    logic [MAX_ELEMENTS-1:0] sym_bits_reg, sym_bits_next;
    logic [LEN_W-1:0] sym_len_reg, sym_len_next;
    logic letter_done_reg, letter_done_next;
    logic word_done_reg, word_done_next;

    logic out_valid_reg;
    mkd_pkg::result_t out_data_reg;
    logic skid_valid_reg;
    mkd_pkg::result_t skid_data_reg;

    logic in_fire;
    logic out_fire;
    logic release_tick;
    logic is_dash;
    logic [COUNT_WIDTH-1:0] gap_inc;
    logic lookup_hit;
    logic [mkd_pkg::CODE_W-1:0] lookup_code;
    logic res_valid;
    mkd_pkg::result_t res;

    assign in_stall = skid_valid_reg;
    assign in_fire = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_ticks_reg <= mkd_pkg::DASH_TICKS_RESET;
            letter_ticks_reg <= mkd_pkg::LETTER_TICKS_RESET;
            word_ticks_reg <= mkd_pkg::WORD_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mkd_pkg::REG_DASH_TICKS: dash_ticks_reg <= cfg_data;
                mkd_pkg::REG_LETTER_TICKS: letter_ticks_reg <= cfg_data;
                mkd_pkg::REG_WORD_TICKS: word_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // code table lookup
    always_comb
    begin
        lookup_hit = 1'b0;
        lookup_code = '0;
        for (int i = 0; i < mkd_pkg::TABLE_SIZE; i++)
        begin
            if ((32'(sym_len_reg) == 32'(mkd_pkg::CODE_TABLE[i].len)) &&
                (32'(sym_bits_reg) == 32'(mkd_pkg::CODE_TABLE[i].bits)))
            begin
                lookup_hit = 1'b1;
                lookup_code = lookup_code | mkd_pkg::CODE_TABLE[i].code;
            end
        end
        if (sym_len_reg > LEN_MAX)
        begin
            lookup_hit = 1'b0;
        end
    end

    // decode one tick
    always_comb
    begin
        release_tick = !key_down && key_prev_reg;
        is_dash = CMP_W'(hold_count_reg) >= CMP_W'(dash_ticks_reg);
        gap_inc = (&gap_count_reg) ? gap_count_reg : gap_count_reg + 1'b1;

        key_prev_next = key_down;
        hold_count_next = hold_count_reg;
        gap_count_next = gap_count_reg;
        sym_bits_next = sym_bits_reg;
        sym_len_next = sym_len_reg;
        letter_done_next = letter_done_reg;
        word_done_next = word_done_reg;
        res_valid = 1'b0;
        res = '{kind: mkd_pkg::EV_ELEMENT, dash: 1'b0, code: '0};

        if (key_down && !key_prev_reg)
        begin
            hold_count_next = COUNT_WIDTH'(1);
        end
        else if (key_down && !(&hold_count_reg))
        begin
            hold_count_next = hold_count_reg + 1'b1;
        end

        if (release_tick)
        begin
            if (sym_len_reg < LEN_MAX)
            begin
                sym_bits_next = {sym_bits_reg[MAX_ELEMENTS-2:0], is_dash};
                sym_len_next = sym_len_reg + 1'b1;
            end
            else
            begin
                sym_len_next = LEN_OVERFLOW;
            end
            gap_count_next = '0;
            letter_done_next = 1'b0;
            word_done_next = 1'b0;
            res_valid = 1'b1;
            res.kind = mkd_pkg::EV_ELEMENT;
            res.dash = is_dash;
        end
        else
        begin
            gap_count_next = gap_inc;
            if (!word_done_reg)
            begin
                if (!letter_done_reg && (CMP_W'(gap_inc) > CMP_W'(letter_ticks_reg)))
                begin
                    sym_bits_next = '0;
                    sym_len_next = '0;
                    letter_done_next = 1'b1;
                    if (lookup_hit)
                    begin
                        res_valid = 1'b1;
                        if (lookup_code == mkd_pkg::ERASE_CODE)
                        begin
                            res.kind = mkd_pkg::EV_ERASE;
                        end
                        else
                        begin
                            res.kind = mkd_pkg::EV_LETTER;
                            res.code = lookup_code;
                        end
                    end
                end
                else if (CMP_W'(gap_inc) > CMP_W'(word_ticks_reg))
                begin
                    word_done_next = 1'b1;
                    res_valid = 1'b1;
                    res.kind = mkd_pkg::EV_WORD;
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_prev_reg <= 1'b0;
            hold_count_reg <= '0;
            gap_count_reg <= '0;
            sym_bits_reg <= '0;
            sym_len_reg <= '0;
            letter_done_reg <= 1'b1;
            word_done_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            key_prev_reg <= key_prev_next;
            hold_count_reg <= hold_count_next;
            gap_count_reg <= gap_count_next;
            sym_bits_reg <= sym_bits_next;
            sym_len_reg <= sym_len_next;
            letter_done_reg <= letter_done_next;
            word_done_reg <= word_done_next;
        end
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire && res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign event_kind = out_data_reg.kind;
    assign element_dash = out_data_reg.dash;
    assign letter_code = out_data_reg.code;

    `MKD_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `MKD_ASSERT(a_len_bound, sym_len_reg <= LEN_OVERFLOW, "symbol length out of range")
    `MKD_ASSERT_NEXT(a_release_clears_gap, in_fire && release_tick, gap_count_reg == '0 && !letter_done_reg, "release did not restart gap")
    `MKD_ASSERT_NEXT(a_event_shown, in_fire && res_valid, out_valid_reg, "event lost")

endmodule
